FILE: rtl/fen_position_parser_defines.svh
// Assertion macros for the FEN position parser RTL.
`ifndef FEN_POSITION_PARSER_DEFINES_SVH
`define FEN_POSITION_PARSER_DEFINES_SVH

// Generic clocked assertion with an explicit clock and active-low reset.
`define FPP_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion on the house clock and reset names.
`define FPP_ASSERT(lbl, prop, msg) `FPP_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/fpp_pkg.sv
// Shared types, constants and character helpers for the FEN position parser.
package fpp_pkg;

  localparam int BoardSide     = 8;
  localparam int ClockWidthDef = 16;
  localparam int OpQueueDepth  = 4;
  localparam int OutQueueDepth = 4;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChThree = 8'h33;
  localparam logic [7:0] ChSix   = 8'h36;
  localparam logic [7:0] ChEight = 8'h38;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowB  = 8'h62;
  localparam logic [7:0] ChLowH  = 8'h68;
  localparam logic [7:0] ChLowW  = 8'h77;
  localparam logic [7:0] ChUpK   = 8'h4B;
  localparam logic [7:0] ChUpQ   = 8'h51;
  localparam logic [7:0] ChLowK  = 8'h6B;
  localparam logic [7:0] ChLowQ  = 8'h71;

  // Field numbers, counted from zero.
  localparam logic [2:0] FieldPlace  = 3'd0;
  localparam logic [2:0] FieldSide   = 3'd1;
  localparam logic [2:0] FieldCastle = 3'd2;
  localparam logic [2:0] FieldPassnt = 3'd3;
  localparam logic [2:0] FieldHalf   = 3'd4;
  localparam logic [2:0] FieldFull   = 3'd5;
  localparam logic [2:0] FieldMax    = 3'd7;

  // Parse status codes.
  localparam logic [3:0] StatusOk       = 4'd0;
  localparam logic [3:0] StatusFew      = 4'd1;
  localparam logic [3:0] StatusPiece    = 4'd2;
  localparam logic [3:0] StatusSide     = 4'd3;
  localparam logic [3:0] StatusCastle   = 4'd4;
  localparam logic [3:0] StatusPassant  = 4'd5;
  localparam logic [3:0] StatusHalf     = 4'd6;
  localparam logic [3:0] StatusFull     = 4'd7;
  localparam logic [3:0] StatusRanks    = 4'd8;

  localparam logic RecSquare  = 1'b0;
  localparam logic RecSummary = 1'b1;

  // Classified character handed from front to back.
  typedef struct packed {
    logic [7:0] ch;
    logic [2:0] fld;       // fields started so far, saturating
    logic       is_space;
    logic       last;
    logic [3:0] piece;     // 0 when not a piece letter
    logic       is_digit;  // '0' through '9'
    logic [3:0] dval;
  } op_t;

  // One result record.
  typedef struct packed {
    logic        kind;
    logic [5:0]  square;
    logic [3:0]  piece;
    logic [3:0]  status;
    logic        white;
    logic [3:0]  castle;
    logic [2:0]  passant;
    logic [15:0] half;
    logic [15:0] full;
    logic        last;
  } rec_t;

  function automatic logic [3:0] piece_of(input logic [7:0] c);
    logic [3:0] p;
    unique case (c)
      8'h50:   p = 4'd1;   // P
      8'h4E:   p = 4'd2;   // N
      8'h42:   p = 4'd3;   // B
      8'h52:   p = 4'd4;   // R
      8'h51:   p = 4'd5;   // Q
      8'h4B:   p = 4'd6;   // K
      8'h70:   p = 4'd7;   // p
      8'h6E:   p = 4'd8;   // n
      8'h62:   p = 4'd9;   // b
      8'h72:   p = 4'd10;  // r
      8'h71:   p = 4'd11;  // q
      8'h6B:   p = 4'd12;  // k
      default: p = 4'd0;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/fpp_queue.sv
// Small register-based FIFO used between the parser stages and at the output.
module fpp_queue #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/fpp_front.sv
// Front stage: splits the character stream into fields and classifies characters.
module fpp_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [7:0]   char_i,
  input  logic         last_i,
  output fpp_pkg::op_t op_o
);
  import fpp_pkg::*;

  logic       in_field_q, in_field_d;
  logic [2:0] fld_q, fld_d;
  logic       is_space;

  assign is_space = (char_i == ChSpace);

  always_comb begin
    in_field_d = in_field_q;
    fld_d      = fld_q;
    if (is_space) begin
      in_field_d = 1'b0;
    end else if (!in_field_q) begin
      in_field_d = 1'b1;
      if (fld_q != FieldMax) begin
        fld_d = fld_q + 1'b1;
      end
    end
  end

  always_comb begin
    op_o.ch       = char_i;
    op_o.fld      = fld_d;
    op_o.is_space = is_space;
    op_o.last     = last_i;
    op_o.piece    = piece_of(char_i);
    op_o.is_digit = (char_i >= ChZero) && (char_i <= ChNine);
    op_o.dval     = 4'(char_i - ChZero);
  end

  // Drop field tracking back to reset once the final character is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_field_q <= 1'b0;
      fld_q      <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        in_field_q <= 1'b0;
        fld_q      <= '0;
      end else begin
        in_field_q <= in_field_d;
        fld_q      <= fld_d;
      end
    end
  end

endmodule

FILE: rtl/fpp_back.sv
// Back stage: updates board and field state and builds square and summary records.
`include "fen_position_parser_defines.svh"

module fpp_back #(
  parameter int ClockWidth = fpp_pkg::ClockWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  fpp_pkg::op_t  op_i,
  input  logic          op_empty_i,
  output logic          op_pop_o,
  input  logic          out_full_i,
  output logic          out_push_o,
  output fpp_pkg::rec_t rec_o
);
  import fpp_pkg::*;

  localparam int CapW = (ClockWidth > 16) ? 16 : ClockWidth;
  localparam int ExtW = CapW + 5;
  localparam logic [CapW-1:0] CapVal = '1;

  logic [3:0]      rank_q, rank_d;
  logic [4:0]      file_q, file_d;
  logic [3:0]      err_q, err_d;
  logic [7:0]      sc0_q, sc0_d, sc1_q, sc1_d;
  logic [3:0]      castle_q, castle_d;
  logic [7:0]      pfirst_q, pfirst_d;
  logic [1:0]      plen_q, plen_d;
  logic [CapW-1:0] half_q, half_d, full_q, full_d;
  logic [2:0]      fld_q;
  logic            pend_q;

  logic            go;
  logic [2:0]      f;
  logic            square_hit;
  logic [5:0]      file_sum;
  logic [CapW-1:0] clk_src, clk_next;
  logic [ExtW-1:0] clk_ext, clk_prod;
  logic [3:0]      status;

  assign go       = !op_empty_i && !out_full_i && !pend_q;
  assign op_pop_o = go;
  assign f        = op_i.fld - 3'd1;
  assign file_sum = {1'b0, file_q} + {2'b0, op_i.dval};

  // Clock digit accumulate: v*10 + d, saturating.
  assign clk_src  = (f == FieldHalf) ? half_q : full_q;
  assign clk_ext  = ExtW'(clk_src);
  assign clk_prod = (clk_ext << 3) + (clk_ext << 1) + ExtW'(op_i.dval);
  assign clk_next = (clk_prod > ExtW'(CapVal)) ? CapVal : clk_prod[CapW-1:0];

  always_comb begin
    rank_d     = rank_q;
    file_d     = file_q;
    err_d      = err_q;
    sc0_d      = sc0_q;
    sc1_d      = sc1_q;
    castle_d   = castle_q;
    pfirst_d   = pfirst_q;
    plen_d     = plen_q;
    half_d     = half_q;
    full_d     = full_q;
    square_hit = 1'b0;
    if (go && !op_i.is_space) begin
      case (f)
        FieldPlace: begin
          if (op_i.ch == ChSlash) begin
            if (rank_q != 4'd15) rank_d = rank_q + 1'b1;
            file_d = '0;
          end else if (op_i.ch >= ChOne && op_i.ch <= ChEight) begin
            file_d = (file_sum > 6'd31) ? 5'd31 : file_sum[4:0];
          end else if (op_i.piece != 4'd0) begin
            square_hit = (rank_q < 4'(BoardSide)) && (file_q < 5'(BoardSide));
            if (file_q != 5'd31) file_d = file_q + 1'b1;
          end else if (err_q == StatusOk) begin
            err_d = StatusPiece;
          end
        end
        FieldSide: begin
          if (op_i.ch != ChLowW && op_i.ch != ChLowB && err_q == StatusOk) begin
            err_d = StatusSide;
          end
          if (sc0_q == 8'd0) begin
            sc0_d = op_i.ch;
          end else if (sc1_q == 8'd0) begin
            sc1_d = op_i.ch;
          end
        end
        FieldCastle: begin
          if (op_i.ch == ChUpK) begin
            castle_d = castle_q | 4'b0001;
          end else if (op_i.ch == ChUpQ) begin
            castle_d = castle_q | 4'b0010;
          end else if (op_i.ch == ChLowK) begin
            castle_d = castle_q | 4'b0100;
          end else if (op_i.ch == ChLowQ) begin
            castle_d = castle_q | 4'b1000;
          end else if (op_i.ch != ChDash && err_q == StatusOk) begin
            err_d = StatusCastle;
          end
        end
        FieldPassnt: begin
          if (!(op_i.ch == ChDash || (op_i.ch >= ChLowA && op_i.ch <= ChLowH) ||
                op_i.ch == ChThree || op_i.ch == ChSix) && err_q == StatusOk) begin
            err_d = StatusPassant;
          end
          if (plen_q == 2'd0) pfirst_d = op_i.ch;
          if (plen_q != 2'd3) plen_d = plen_q + 1'b1;
        end
        FieldHalf: begin
          if (op_i.is_digit) begin
            half_d = clk_next;
          end else if (err_q == StatusOk) begin
            err_d = StatusHalf;
          end
        end
        FieldFull: begin
          if (op_i.is_digit) begin
            full_d = clk_next;
          end else if (err_q == StatusOk) begin
            err_d = StatusFull;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fld_q < 3'd4) begin
      status = StatusFew;
    end else if (err_q != StatusOk) begin
      status = err_q;
    end else if (rank_q < 4'(BoardSide - 1)) begin
      status = StatusRanks;
    end else begin
      status = StatusOk;
    end
  end

  always_comb begin
    rec_o = '0;
    if (pend_q) begin
      rec_o.kind   = RecSummary;
      rec_o.status = status;
      rec_o.white  = !(sc0_q == ChLowB && sc1_q == 8'd0);
      rec_o.castle = castle_q;
      if (plen_q > 2'd1 && pfirst_q >= ChLowA && pfirst_q <= ChLowH) begin
        rec_o.passant = 3'(pfirst_q - ChLowA);
      end
      rec_o.half   = 16'(half_q);
      rec_o.full   = 16'(full_q);
      rec_o.last   = 1'b1;
    end else begin
      rec_o.kind   = RecSquare;
      rec_o.square = {3'(BoardSide - 1) - rank_q[2:0], file_q[2:0]};
      rec_o.piece  = op_i.piece;
    end
  end

  assign out_push_o = pend_q ? !out_full_i : square_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q   <= '0;
      file_q   <= '0;
      err_q    <= StatusOk;
      sc0_q    <= '0;
      sc1_q    <= '0;
      castle_q <= '0;
      pfirst_q <= '0;
      plen_q   <= '0;
      half_q   <= '0;
      full_q   <= '0;
      fld_q    <= '0;
      pend_q   <= 1'b0;
    end else if (pend_q) begin
      // Summary goes out once there is room; then clear for the next string.
      if (!out_full_i) begin
        rank_q   <= '0;
        file_q   <= '0;
        err_q    <= StatusOk;
        sc0_q    <= '0;
        sc1_q    <= '0;
        castle_q <= '0;
        pfirst_q <= '0;
        plen_q   <= '0;
        half_q   <= '0;
        full_q   <= '0;
        fld_q    <= '0;
        pend_q   <= 1'b0;
      end
    end else begin
      rank_q   <= rank_d;
      file_q   <= file_d;
      err_q    <= err_d;
      sc0_q    <= sc0_d;
      sc1_q    <= sc1_d;
      castle_q <= castle_d;
      pfirst_q <= pfirst_d;
      plen_q   <= plen_d;
      half_q   <= half_d;
      full_q   <= full_d;
      if (go && op_i.last) begin
        fld_q  <= op_i.fld;
        pend_q <= 1'b1;
      end
    end
  end

  `FPP_ASSERT(a_pend_blocks_pop, pend_q |-> !op_pop_o, "op taken while summary pending")
  `FPP_ASSERT(a_last_sets_pend, (op_pop_o && op_i.last) |=> pend_q, "last op did not arm summary")
  `FPP_ASSERT(a_square_only_place, (out_push_o && !pend_q) |-> (f == FieldPlace && go),
              "square record outside placement field")
  `FPP_ASSERT(a_no_push_when_full, out_full_i |-> !out_push_o, "record pushed into full queue")

endmodule

FILE: rtl/fen_position_parser.sv
// Top level of the streaming FEN position parser.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------------
//  input     | push / full        | char_in_i, end_of_text_i
//  result    | empty / pop        | record_kind_o .. record_last_o (one record)
//
//  Sustained rate is one character per cycle while full is low; each character is
//  classified by the front stage and written to a small op queue in the cycle it is
//  accepted. The back stage retires one op per cycle unless its op queue is empty,
//  the result queue is full or a summary is pending; a final character arms the
//  pending summary, written to the result queue once it has room. Square records
//  pass the op queue and then the result queue on their way to the result ports.
//  Reset (rst_ni low, asynchronous) empties both queues and clears all parse state.
//  full rises when the op queue fills; a stalled result side backs up through the
//  result queue and then the op queue, so no request is ever lost.
module fen_position_parser #(
  parameter int ClockWidth = fpp_pkg::ClockWidthDef,
  parameter int OpDepth    = fpp_pkg::OpQueueDepth,
  parameter int OutDepth   = fpp_pkg::OutQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_in_i,
  input  logic        end_of_text_i,
  output logic        empty,
  input  logic        pop,
  output logic        record_kind_o,
  output logic [5:0]  square_index_o,
  output logic [3:0]  piece_code_o,
  output logic [3:0]  parse_status_o,
  output logic        white_moves_o,
  output logic [3:0]  castle_rights_o,
  output logic [2:0]  passant_column_o,
  output logic [15:0] half_move_count_o,
  output logic [15:0] full_move_count_o,
  output logic        record_last_o
);
  import fpp_pkg::*;

  logic accept;
  op_t  op_in, op_head;
  logic op_empty, op_pop;
  rec_t rec_in, rec_head;
  logic out_full, out_push;

  // Take a request whenever the op queue has room.
  assign accept = push && !full;

  fpp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .char_i   (char_in_i),
    .last_i   (end_of_text_i),
    .op_o     (op_in)
  );

  // Decouple classification from execution.
  fpp_queue #(
    .Width ($bits(op_t)),
    .Depth (OpDepth)
  ) u_op_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (op_in),
    .full_o  (full),
    .pop_i   (op_pop),
    .data_o  (op_head),
    .empty_o (op_empty)
  );

  fpp_back #(
    .ClockWidth (ClockWidth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op_head),
    .op_empty_i (op_empty),
    .op_pop_o   (op_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .rec_o      (rec_in)
  );

  // Hold finished records until the consumer pops them.
  fpp_queue #(
    .Width ($bits(rec_t)),
    .Depth (OutDepth)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (rec_in),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (rec_head),
    .empty_o (empty)
  );

  assign record_kind_o     = rec_head.kind;
  assign square_index_o    = rec_head.square;
  assign piece_code_o      = rec_head.piece;
  assign parse_status_o    = rec_head.status;
  assign white_moves_o     = rec_head.white;
  assign castle_rights_o   = rec_head.castle;
  assign passant_column_o  = rec_head.passant;
  assign half_move_count_o = rec_head.half;
  assign full_move_count_o = rec_head.full;
  assign record_last_o     = rec_head.last;

endmodule

FILE: test/fen_position_parser_tb.sv
// Self-checking testbench for the streaming FEN position parser.
module fen_position_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpp_pkg::*;

  // Cycles without any accepted request before the run is declared hung.
  localparam int WatchdogLimit = 2000;
  // Receiver hold-off used to back the block up into its input.
  localparam int HoldCycles    = 300;
  // Random part stops once this many characters have gone in.
  localparam int CharTarget    = 1400;
  // Clocks saturate at the smaller of the clock range and 16 bits.
  localparam int ClockCap      = (ClockWidthDef >= 16) ? 65535 : (1 << ClockWidthDef) - 1;

  typedef enum logic [3:0] {
    PcNone, PcWhitePawn, PcWhiteKnight, PcWhiteBishop, PcWhiteRook, PcWhiteQueen,
    PcWhiteKing, PcBlackPawn, PcBlackKnight, PcBlackBishop, PcBlackRook, PcBlackQueen,
    PcBlackKing
  } piece_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  char_in_i;
  logic        end_of_text_i;
  logic        empty;
  logic        pop;
  logic        record_kind_o;
  logic [5:0]  square_index_o;
  logic [3:0]  piece_code_o;
  logic [3:0]  parse_status_o;
  logic        white_moves_o;
  logic [3:0]  castle_rights_o;
  logic [2:0]  passant_column_o;
  logic [15:0] half_move_count_o;
  logic [15:0] full_move_count_o;
  logic        record_last_o;

  fen_position_parser dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .char_in_i         (char_in_i),
    .end_of_text_i     (end_of_text_i),
    .empty             (empty),
    .pop               (pop),
    .record_kind_o     (record_kind_o),
    .square_index_o    (square_index_o),
    .piece_code_o      (piece_code_o),
    .parse_status_o    (parse_status_o),
    .white_moves_o     (white_moves_o),
    .castle_rights_o   (castle_rights_o),
    .passant_column_o  (passant_column_o),
    .half_move_count_o (half_move_count_o),
    .full_move_count_o (full_move_count_o),
    .record_last_o     (record_last_o)
  );

  always #10 clk_i = ~clk_i;

  // Parser state mirrored by the predictor.
  logic [2:0]  fields_seen;
  logic        inside_field;
  logic [3:0]  slash_count;
  logic [4:0]  file_col;
  logic [3:0]  first_error;
  logic [7:0]  side_first;
  logic [7:0]  side_second;
  logic [3:0]  castle_seen;
  logic [7:0]  ep_first;
  logic [1:0]  ep_len;
  logic [15:0] half_acc;
  logic [15:0] full_acc;

  rec_t        pending_records[$];
  rec_t        head_record;
  logic [7:0]  fen_chars[$];

  int          mismatches   = 0;
  int          chars_sent   = 0;
  int          quiet_cycles = 0;
  int unsigned tx_idle_pct  = 14;
  int unsigned rx_idle_pct  = 14;
  bit          hold_req     = 1'b0;

  string piece_letters  = "PNBRQKpnbrqk";
  string castle_letters = "KQkq";
  string castle_noise   = "-KQkqxZ";

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic piece_e piece_code_for(input logic [7:0] c);
    case (c)
      "P":     return PcWhitePawn;
      "N":     return PcWhiteKnight;
      "B":     return PcWhiteBishop;
      "R":     return PcWhiteRook;
      "Q":     return PcWhiteQueen;
      "K":     return PcWhiteKing;
      "p":     return PcBlackPawn;
      "n":     return PcBlackKnight;
      "b":     return PcBlackBishop;
      "r":     return PcBlackRook;
      "q":     return PcBlackQueen;
      "k":     return PcBlackKing;
      default: return PcNone;
    endcase
  endfunction

  // Append one decimal digit to a clock, saturating at the cap.
  function automatic logic [15:0] clock_step(input logic [15:0] v, input logic [7:0] c);
    logic [31:0] n;
    n = {16'd0, v} * 32'd10 + 32'(c - ChZero);
    return (n > ClockCap) ? 16'(ClockCap) : n[15:0];
  endfunction

  task automatic clear_parse_state();
    fields_seen  = '0;
    inside_field = 1'b0;
    slash_count  = '0;
    file_col     = '0;
    first_error  = StatusOk;
    side_first   = '0;
    side_second  = '0;
    castle_seen  = '0;
    ep_first     = '0;
    ep_len       = '0;
    half_acc     = '0;
    full_acc     = '0;
  endtask

  // Keep only the first error of the string.
  task automatic note_error(input logic [3:0] code);
    if (first_error == StatusOk) first_error = code;
  endtask

  // Advance the mirrored parser by one accepted character and queue its records.
  task automatic parse_char(input logic [7:0] c, input logic eot);
    logic [2:0] fld;
    piece_e     pc;
    int         col;
    rec_t       rec;
    if (c == ChSpace) begin
      inside_field = 1'b0;
    end else begin
      if (!inside_field) begin
        inside_field = 1'b1;
        if (fields_seen != FieldMax) fields_seen++;
      end
      fld = fields_seen - 3'd1;
      case (fld)
        FieldPlace: begin
          pc = piece_code_for(c);
          if (c == ChSlash) begin
            if (slash_count != 4'd15) slash_count++;
            file_col = '0;
          end else if (c >= ChOne && c <= ChEight) begin
            col      = int'(file_col) + int'(c - ChZero);
            file_col = (col > 31) ? 5'd31 : 5'(col);
          end else if (pc != PcNone) begin
            // Squares off the board are swallowed without a record.
            if (slash_count < BoardSide && file_col < BoardSide) begin
              rec        = '0;
              rec.kind   = RecSquare;
              rec.square = 6'((BoardSide - 1 - int'(slash_count)) * BoardSide + int'(file_col));
              rec.piece  = pc;
              pending_records.push_back(rec);
            end
            if (file_col != 5'd31) file_col++;
          end else begin
            note_error(StatusPiece);
          end
        end
        FieldSide: begin
          if (c != ChLowW && c != ChLowB) note_error(StatusSide);
          // A zero byte leaves its slot open for the next character.
          if (side_first == 8'd0) side_first = c;
          else if (side_second == 8'd0) side_second = c;
        end
        FieldCastle: begin
          if (c == ChUpK) castle_seen[0] = 1'b1;
          else if (c == ChUpQ) castle_seen[1] = 1'b1;
          else if (c == ChLowK) castle_seen[2] = 1'b1;
          else if (c == ChLowQ) castle_seen[3] = 1'b1;
          else if (c != ChDash) note_error(StatusCastle);
        end
        FieldPassnt: begin
          if (!(c == ChDash || (c >= ChLowA && c <= ChLowH) || c == ChThree || c == ChSix))
            note_error(StatusPassant);
          if (ep_len == 2'd0) ep_first = c;
          if (ep_len != 2'd3) ep_len++;
        end
        FieldHalf: begin
          if (c >= ChZero && c <= ChNine) half_acc = clock_step(half_acc, c);
          else note_error(StatusHalf);
        end
        FieldFull: begin
          if (c >= ChZero && c <= ChNine) full_acc = clock_step(full_acc, c);
          else note_error(StatusFull);
        end
        default: begin
          // Fields past the sixth carry nothing.
        end
      endcase
    end

    if (eot) begin
      rec      = '0;
      rec.kind = RecSummary;
      // Field shortfall beats any field error, which beats a missing rank.
      if (fields_seen < 3'd4) rec.status = StatusFew;
      else if (first_error != StatusOk) rec.status = first_error;
      else if (int'(slash_count) + 1 < BoardSide) rec.status = StatusRanks;
      else rec.status = StatusOk;
      rec.white  = !(side_first == ChLowB && side_second == 8'd0);
      rec.castle = castle_seen;
      // A lone en passant character never yields a column.
      if (ep_len > 2'd1 && ep_first >= ChLowA && ep_first <= ChLowH)
        rec.passant = 3'(ep_first - ChLowA);
      rec.half = half_acc;
      rec.full = full_acc;
      rec.last = 1'b1;
      pending_records.push_back(rec);
      clear_parse_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random pop with an optional long hold-off
  // ---------------------------------------------------------------------------

  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        // Hold pop low so the result and op queues fill and full rises.
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each popped record against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_records.size() == 0) begin
        $error("record_kind: expected none, got %0d (unexpected record)", record_kind_o);
        mismatches++;
      end else begin
        head_record = pending_records.pop_front();
        check_field("record_kind",     head_record.kind,    record_kind_o);
        check_field("square_index",    head_record.square,  square_index_o);
        check_field("piece_code",      head_record.piece,   piece_code_o);
        check_field("parse_status",    head_record.status,  parse_status_o);
        check_field("white_moves",     head_record.white,   white_moves_o);
        check_field("castle_rights",   head_record.castle,  castle_rights_o);
        check_field("passant_column",  head_record.passant, passant_column_o);
        check_field("half_move_count", head_record.half,    half_move_count_o);
        check_field("full_move_count", head_record.full,    full_move_count_o);
        check_field("record_last",     head_record.last,    record_last_o);
      end
    end
  end

  // Watchdog: end the run when no request moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one character; push stays high afterwards so back-to-back requests
  // need no second assignment in the same step.
  task automatic send_char(input logic [7:0] c, input logic eot);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    char_in_i     <= c;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (full);
    parse_char(c, eot);
    chars_sent++;
  endtask

  // Send the assembled string, flagging its final character.
  task automatic send_text();
    int n;
    n = fen_chars.size();
    for (int i = 0; i < n; i++) send_char(fen_chars[i], i == n - 1);
    fen_chars.delete();
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) fen_chars.push_back(s[i]);
  endtask

  // Mostly one space, now and then a run of them.
  task automatic put_gap();
    repeat (($urandom_range(7) == 0) ? $urandom_range(2, 3) : 1) fen_chars.push_back(ChSpace);
  endtask

  // Short clocks mostly, long ones to reach saturation, and the cap edge.
  task automatic put_clock();
    case ($urandom_range(15))
      0:       put_str("65535");
      1:       put_str("65536");
      2, 3:    repeat ($urandom_range(5, 7)) fen_chars.push_back(8'(ChZero + $urandom_range(9)));
      default: repeat ($urandom_range(1, 2)) fen_chars.push_back(8'(ChZero + $urandom_range(9)));
    endcase
  endtask

  // Assemble a mostly well-formed position with random content and the odd defect.
  task automatic build_position();
    int ranks;
    int file;
    int d;
    int k;
    if ($urandom_range(9) == 0) put_gap();
    ranks = ($urandom_range(9) == 0) ? $urandom_range(6, 9) : BoardSide;
    for (int r = 0; r < ranks; r++) begin
      if (r != 0) fen_chars.push_back(ChSlash);
      file = 0;
      while (file < BoardSide) begin
        if ($urandom_range(2) == 0) begin
          d = $urandom_range(1, BoardSide - file);
          fen_chars.push_back(8'(ChZero + d));
          file += d;
        end else begin
          fen_chars.push_back(piece_letters[$urandom_range(11)]);
          file++;
        end
      end
      // Overfull rank: pieces past the edge, sometimes after the file saturates.
      if ($urandom_range(14) == 0) begin
        repeat ($urandom_range(0, 4)) fen_chars.push_back(ChEight);
        fen_chars.push_back(piece_letters[$urandom_range(11)]);
      end
    end

    put_gap();
    case ($urandom_range(9))
      0, 1, 2, 3: put_str("w");
      4, 5, 6:    put_str("b");
      7:          put_str("bb");
      8: begin
        put_str("b");
        fen_chars.push_back(8'h00);
      end
      default:    fen_chars.push_back(8'($urandom_range(255)));
    endcase

    put_gap();
    if ($urandom_range(3) == 0) begin
      put_str("-");
    end else begin
      k = 0;
      for (int i = 0; i < 4; i++) begin
        if ($urandom_range(1) == 1) begin
          fen_chars.push_back(castle_letters[i]);
          k++;
        end
      end
      if (k == 0) put_str("-");
    end
    if ($urandom_range(11) == 0) fen_chars.push_back(castle_noise[$urandom_range(6)]);

    put_gap();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: put_str("-");
      5, 6, 7: begin
        fen_chars.push_back(8'(ChLowA + $urandom_range(7)));
        fen_chars.push_back(($urandom_range(1) == 1) ? ChThree : ChSix);
      end
      8: begin
        // Letter outside a..h gives column zero.
        fen_chars.push_back(8'(ChLowA + $urandom_range(25)));
        fen_chars.push_back(8'(ChZero + $urandom_range(9)));
      end
      default: fen_chars.push_back(8'(ChLowA + $urandom_range(7)));
    endcase

    put_gap();
    put_clock();
    put_gap();
    put_clock();

    if ($urandom_range(9) == 0) begin
      put_gap();
      put_clock();
    end
    if ($urandom_range(9) == 0) put_gap();

    // Corrupt one character now and then.
    if ($urandom_range(9) == 0) fen_chars[$urandom_range(fen_chars.size() - 1)] = 8'($urandom_range(255));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short hand-written strings: black to move with missing ranks, a lone
  // space, and one with a bad placement digit, a zero byte in the side field,
  // a single en passant character and a saturating clock.
  task automatic test_directed();
    put_str("K b Qq e3 9 7");
    send_text();
    put_str(" ");
    send_text();
    put_str("1/0 b");
    fen_chars.push_back(8'h00);
    put_str(" - a 70000");
    send_text();
  endtask

  // Bulk of the run: well-formed positions, truncated ones and raw noise.
  task automatic test_random_positions();
    int mode;
    int cut;
    while (chars_sent < CharTarget) begin
      mode = $urandom_range(99);
      if (mode < 70) begin
        build_position();
      end else if (mode < 85) begin
        build_position();
        cut = $urandom_range(fen_chars.size() - 1);
        fen_chars = fen_chars[0:cut];
      end else begin
        repeat ($urandom_range(1, 16)) begin
          if ($urandom_range(3) == 0) fen_chars.push_back(ChSpace);
          else fen_chars.push_back(8'($urandom_range(255)));
        end
      end
      send_text();
    end
  endtask

  // Stall the result side while the sender keeps offering, so full rises.
  task automatic test_back_pressure();
    hold_req = 1'b1;
    repeat (4) begin
      build_position();
      send_text();
    end
  endtask

  // Long stretch with no idling on either side.
  task automatic test_no_gaps();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (6) begin
      build_position();
      send_text();
    end
    tx_idle_pct = 14;
    rx_idle_pct = 14;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    push          <= 1'b0;
    char_in_i     <= '0;
    end_of_text_i <= 1'b0;
    clear_parse_state();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_positions();
    test_back_pressure();
    test_no_gaps();
    push <= 1'b0;

    // Drain, then give stray records time to show up.
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0 && pending_records.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
